// ===== design/assert_macros.svh =====
// assertion macros shared by the heat diffusion stencil rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("heat diffusion stencil: implication check failed");
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("heat diffusion stencil: next-cycle check failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== design/hds_pkg.sv =====
// package: payload types, widths and register codes of the heat diffusion stencil
`timescale 1ns / 1ps
`default_nettype none

package hds_pkg;

    localparam int TEMP_W     = 32;
    localparam int COEF_W     = 16;
    localparam int GAIN_W     = 16;
    localparam int THRESH_W   = 31;
    localparam int CFG_DATA_W = 31;
    localparam int CFG_IDX_W  = 1;

    // shared multiplier operands: value or partial sum by coefficient or gain
    localparam int MUL_A_W = 33;
    localparam int MUL_B_W = 18;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    localparam int ACC_W      = 52;
    localparam int FRAC_SHIFT = 24;
    localparam int HI_W       = ACC_W - FRAC_SHIFT;
    localparam int LO_PROD_W  = FRAC_SHIFT + GAIN_W;
    localparam int HI_PROD_W  = HI_W + GAIN_W;
    localparam int FRAC_W     = LO_PROD_W + 1 - FRAC_SHIFT;
    localparam int DU_W       = 46;
    localparam int NV_W       = DU_W + 1;

    localparam logic [GAIN_W-1:0]   GAIN_RESET   = 16'd745;
    localparam logic [THRESH_W-1:0] THRESH_RESET = 31'd7;
    localparam logic [LO_PROD_W:0]  ROUND_HALF   = (LO_PROD_W + 1)'(1) << (FRAC_SHIFT - 1);

    localparam logic [CFG_IDX_W-1:0] REG_STEP_GAIN       = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_CONVERGE_THRESH = 1'b1;

    typedef struct packed {
        logic signed [TEMP_W-1:0] cell_temperature;
        logic [COEF_W-1:0]        cell_coefficient;
        logic                     last_in_sweep;
    } cell_in_t;

    typedef struct packed {
        logic signed [TEMP_W-1:0] new_temperature;
        logic [THRESH_W-1:0]      residual;
        logic                     converged;
        logic                     end_of_sweep;
    } cell_out_t;

endpackage

`default_nettype wire

// ===== design/heat_diffusion_stencil_1d_top.sv =====
// top level: one explicit 1d heat equation time step over a streamed cell array
//
//  port group   dir   transfer when          carries
//  s_*          in    s_valid && s_ready     cell_in_t: temperature, coefficient, last mark
//  m_*          out   m_valid && m_ready     cell_out_t: new temperature, residual, flags
//  cfg_*        in    cfg_wr_en              step gain (index 0), converge threshold (index 1)
//
//  an interior cell keeps s_ready low after its transfer until the sequencer returns to idle:
//  the 33x18 multiplier is used five times (three stencil products, two gain partial
//  products) behind a small sequencer, plus accumulate, combine and result load
//  the first cell of a sweep is only stored, the second emits a boundary result, the final cell one more
//  reset is synchronous, active low, and clears the window and the sweep state
//  a result waits in the output register while the next cell is taken in; the
//  sequencer stalls only when a new result is ready and the register is still full
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module heat_diffusion_stencil_1d_top (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire hds_pkg::cell_in_t                   s_data,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output hds_pkg::cell_out_t                       m_data,
    input  wire logic                                cfg_wr_en,
    input  wire logic [hds_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [hds_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

    typedef enum logic [9:0] {
        ST_IDLE  = 10'b0000000001,
        ST_MUL0  = 10'b0000000010,
        ST_MUL1  = 10'b0000000100,
        ST_MUL2  = 10'b0000001000,
        ST_ACC   = 10'b0000010000,
        ST_GLO   = 10'b0000100000,
        ST_GHI   = 10'b0001000000,
        ST_DU    = 10'b0010000000,
        ST_EMIT0 = 10'b0100000000,
        ST_EMIT1 = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;

    logic [hds_pkg::GAIN_W-1:0]   step_gain_reg;
    logic [hds_pkg::THRESH_W-1:0] thresh_reg;

    logic signed [hds_pkg::TEMP_W-1:0] before_reg, before_next;
    logic signed [hds_pkg::TEMP_W-1:0] held_reg, held_next;
    logic [hds_pkg::COEF_W-1:0]        held_coef_reg, held_coef_next;
    logic [1:0]                        cells_seen_reg, cells_seen_next;
    logic [hds_pkg::THRESH_W-1:0]      max_change_reg, max_change_next;

    logic signed [hds_pkg::TEMP_W-1:0] t_reg, t_next;
    logic [hds_pkg::COEF_W-1:0]        c_reg, c_next;
    logic                              last_reg, last_next;

    logic signed [hds_pkg::ACC_W-1:0]  acc_reg, acc_next;
    logic [hds_pkg::FRAC_W-1:0]        frac_reg, frac_next;
    logic signed [hds_pkg::DU_W-1:0]   du_reg, du_next;

    hds_pkg::cell_out_t out_reg, out_next;
    logic               m_valid_reg, m_valid_next;
    logic               out_load;

    logic signed [hds_pkg::MUL_A_W-1:0] mul_a;
    logic signed [hds_pkg::MUL_B_W-1:0] mul_b;
    logic signed [hds_pkg::PROD_W-1:0]  prod;

    logic                              in_xfer;
    logic                              out_free;
    logic [hds_pkg::LO_PROD_W:0]       lo_round;
    logic [hds_pkg::DU_W-1:0]          du_abs;
    logic [hds_pkg::THRESH_W-1:0]      du_mag;
    logic [hds_pkg::THRESH_W-1:0]      max_new;
    logic signed [hds_pkg::NV_W-1:0]   nv_wide;
    logic signed [hds_pkg::TEMP_W-1:0] nv;
    logic                              sweep_clear;

    assign s_ready  = (state_reg == ST_IDLE);
    assign in_xfer  = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = out_reg;

    // window and running maximum back at the start of a sweep
    assign sweep_clear = (cells_seen_reg == 2'd0) && (max_change_reg == '0);

    hds_mul #(
        .A_W (hds_pkg::MUL_A_W),
        .B_W (hds_pkg::MUL_B_W)
    ) u_mul (
        .aclk    (aclk),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .product (prod)
    );

    // operand steering for the shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_MUL0: begin
                mul_a = hds_pkg::MUL_A_W'(before_reg);
                mul_b = $signed({2'b00, held_coef_reg});
            end
            ST_MUL1: begin
                mul_a = hds_pkg::MUL_A_W'(t_reg);
                mul_b = $signed({2'b00, c_reg});
            end
            ST_MUL2: begin
                mul_a = hds_pkg::MUL_A_W'(held_reg);
                mul_b = $signed({1'b0, 17'({1'b0, held_coef_reg}) + 17'({1'b0, c_reg})});
            end
            ST_GLO: begin
                mul_a = $signed({9'b0, acc_reg[hds_pkg::FRAC_SHIFT-1:0]});
                mul_b = $signed({2'b00, step_gain_reg});
            end
            ST_GHI: begin
                mul_a = hds_pkg::MUL_A_W'(
                            $signed(acc_reg[hds_pkg::ACC_W-1:hds_pkg::FRAC_SHIFT]));
                mul_b = $signed({2'b00, step_gain_reg});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // rounding of the low partial product, magnitude and saturated new value
    always_comb begin
        lo_round = {1'b0, prod[hds_pkg::LO_PROD_W-1:0]} + hds_pkg::ROUND_HALF;
        du_abs   = du_reg[hds_pkg::DU_W-1] ? hds_pkg::DU_W'(-du_reg) : hds_pkg::DU_W'(du_reg);
        du_mag   = (|du_abs[hds_pkg::DU_W-1:hds_pkg::THRESH_W]) ? '1
                                                                : du_abs[hds_pkg::THRESH_W-1:0];
        max_new  = (du_mag > max_change_reg) ? du_mag : max_change_reg;
        nv_wide  = hds_pkg::NV_W'(held_reg) + hds_pkg::NV_W'(du_reg);
        if (!nv_wide[hds_pkg::NV_W-1] && (|nv_wide[hds_pkg::NV_W-2:hds_pkg::TEMP_W-1])) begin
            nv = {1'b0, {(hds_pkg::TEMP_W-1){1'b1}}};
        end else if (nv_wide[hds_pkg::NV_W-1]
                     && !(&nv_wide[hds_pkg::NV_W-2:hds_pkg::TEMP_W-1])) begin
            nv = {1'b1, {(hds_pkg::TEMP_W-1){1'b0}}};
        end else begin
            nv = nv_wide[hds_pkg::TEMP_W-1:0];
        end
    end

    // sequencer
    always_comb begin
        state_next      = state_reg;
        before_next     = before_reg;
        held_next       = held_reg;
        held_coef_next  = held_coef_reg;
        cells_seen_next = cells_seen_reg;
        max_change_next = max_change_reg;
        t_next          = t_reg;
        c_next          = c_reg;
        last_next       = last_reg;
        acc_next        = acc_reg;
        frac_next       = frac_reg;
        du_next         = du_reg;
        out_next        = out_reg;
        out_load        = 1'b0;
        m_valid_next    = m_valid_reg && !m_ready;

        case (state_reg)
            ST_IDLE: begin
                if (in_xfer) begin
                    t_next    = s_data.cell_temperature;
                    c_next    = s_data.cell_coefficient;
                    last_next = s_data.last_in_sweep;
                    case (cells_seen_reg)
                        2'd0: begin
                            max_change_next = '0;
                            if (s_data.last_in_sweep) begin
                                state_next = ST_EMIT0;
                            end else begin
                                held_next       = s_data.cell_temperature;
                                held_coef_next  = s_data.cell_coefficient;
                                cells_seen_next = 2'd1;
                            end
                        end
                        2'd1: begin
                            state_next = ST_EMIT0;
                        end
                        default: begin
                            state_next = ST_MUL0;
                        end
                    endcase
                end
            end
            ST_MUL0: begin
                state_next = ST_MUL1;
            end
            ST_MUL1: begin
                acc_next   = hds_pkg::ACC_W'(prod);
                state_next = ST_MUL2;
            end
            ST_MUL2: begin
                acc_next   = acc_reg + hds_pkg::ACC_W'(prod);
                state_next = ST_ACC;
            end
            ST_ACC: begin
                acc_next   = acc_reg - hds_pkg::ACC_W'(prod);
                state_next = ST_GLO;
            end
            ST_GLO: begin
                state_next = ST_GHI;
            end
            ST_GHI: begin
                frac_next  = lo_round[hds_pkg::LO_PROD_W:hds_pkg::FRAC_SHIFT];
                state_next = ST_DU;
            end
            ST_DU: begin
                // floor((s*gain + half) / 2^24) from the two partial products
                du_next = hds_pkg::DU_W'($signed(prod[hds_pkg::HI_PROD_W-1:0]))
                        + hds_pkg::DU_W'($signed({1'b0, frac_reg}));
                state_next = ST_EMIT0;
            end
            ST_EMIT0: begin
                if (out_free) begin
                    out_load     = 1'b1;
                    m_valid_next = 1'b1;
                    case (cells_seen_reg)
                        2'd0: begin
                            // single-cell sweep passes through as the final result
                            out_next.new_temperature = t_reg;
                            out_next.residual        = '0;
                            out_next.converged       = 1'b1;
                            out_next.end_of_sweep    = 1'b1;
                        end
                        2'd1: begin
                            out_next.new_temperature = held_reg;
                            out_next.residual        = max_change_reg;
                            out_next.converged       = 1'b0;
                            out_next.end_of_sweep    = 1'b0;
                        end
                        default: begin
                            out_next.new_temperature = nv;
                            out_next.residual        = max_new;
                            out_next.converged       = 1'b0;
                            out_next.end_of_sweep    = 1'b0;
                            max_change_next          = max_new;
                        end
                    endcase
                    if (cells_seen_reg == 2'd0) begin
                        state_next = ST_IDLE;
                    end else if (last_reg) begin
                        state_next = ST_EMIT1;
                    end else begin
                        before_next     = held_reg;
                        held_next       = t_reg;
                        held_coef_next  = c_reg;
                        cells_seen_next = 2'd2;
                        state_next      = ST_IDLE;
                    end
                end
            end
            ST_EMIT1: begin
                if (out_free) begin
                    out_load                 = 1'b1;
                    m_valid_next             = 1'b1;
                    out_next.new_temperature = t_reg;
                    out_next.residual        = max_change_reg;
                    out_next.converged       = (max_change_reg <= thresh_reg);
                    out_next.end_of_sweep    = 1'b1;
                    // sweep restarts
                    cells_seen_next          = 2'd0;
                    max_change_next          = '0;
                    before_next              = '0;
                    held_next                = '0;
                    held_coef_next           = '0;
                    state_next               = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            m_valid_reg    <= 1'b0;
            step_gain_reg  <= hds_pkg::GAIN_RESET;
            thresh_reg     <= hds_pkg::THRESH_RESET;
            before_reg     <= '0;
            held_reg       <= '0;
            held_coef_reg  <= '0;
            cells_seen_reg <= 2'd0;
            max_change_reg <= '0;
        end else begin
            state_reg      <= state_next;
            m_valid_reg    <= m_valid_next;
            before_reg     <= before_next;
            held_reg       <= held_next;
            held_coef_reg  <= held_coef_next;
            cells_seen_reg <= cells_seen_next;
            max_change_reg <= max_change_next;
            if (cfg_wr_en) begin
                case (cfg_index)
                    hds_pkg::REG_STEP_GAIN: begin
                        step_gain_reg <= cfg_wdata[hds_pkg::GAIN_W-1:0];
                    end
                    hds_pkg::REG_CONVERGE_THRESH: begin
                        thresh_reg <= cfg_wdata[hds_pkg::THRESH_W-1:0];
                    end
                    default: begin
                        thresh_reg <= thresh_reg;
                    end
                endcase
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        t_reg    <= t_next;
        c_reg    <= c_next;
        last_reg <= last_next;
        acc_reg  <= acc_next;
        frac_reg <= frac_next;
        du_reg   <= du_next;
        out_reg  <= out_next;
    end

    `ASSERT_IMPLIES(a_conv_only_at_end, aclk, aresetn, m_valid && m_data.converged, m_data.end_of_sweep)
    `ASSERT_IMPLIES(a_second_result_last, aclk, aresetn, state_reg == ST_EMIT1, last_reg)
    `ASSERT_NEXT(a_sweep_restart, aclk, aresetn, out_load && out_next.end_of_sweep, sweep_clear)

endmodule

`default_nettype wire

// ===== design/hds_mul.sv =====
// shared signed multiplier with registered product
`timescale 1ns / 1ps
`default_nettype none

module hds_mul #(
    parameter int A_W = hds_pkg::MUL_A_W,
    parameter int B_W = hds_pkg::MUL_B_W
) (
    input  wire logic                    aclk,
    input  wire logic signed [A_W-1:0]   op_a,
    input  wire logic signed [B_W-1:0]   op_b,
    output logic signed [A_W+B_W-1:0]    product
);

    logic signed [A_W+B_W-1:0] product_reg;

    always_ff @(posedge aclk) begin
        product_reg <= (A_W + B_W)'(op_a) * (A_W + B_W)'(op_b);
    end

    assign product = product_reg;

endmodule

`default_nettype wire
